FILE: design/sdkl_pkg.sv
// Package for the sorted date-keyed list: sizes, item structs, codes and state type.
// No dependencies; imported by sdkl_cmp and sorted_date_keyed_list.
package sdkl_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int MATCH_W     = $clog2(MAX_RESULTS + 1);
  localparam int ID_W        = 27;
  localparam int DATE_W      = 21;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_DUP       = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ID_W-1:0]   person_id;
    logic [DATE_W-1:0] birth_date;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic [ID_W-1:0] match_id;
    logic [4:0]      entry_count;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic id_eq;
    logic date_eq;
    logic date_gt;
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

endpackage

FILE: design/sdkl_cmp.sv
// Shared compare unit: checks one stored entry against the item's key.
// Depends on sdkl_pkg.
module sdkl_cmp (
  input  logic [sdkl_pkg::ID_W-1:0]   key_id,
  input  logic [sdkl_pkg::DATE_W-1:0] key_date,
  input  logic [sdkl_pkg::ID_W-1:0]   ent_id,
  input  logic [sdkl_pkg::DATE_W-1:0] ent_date,
  output sdkl_pkg::cmp_res_t          res
);
  import sdkl_pkg::*;

  always_comb begin
    res.id_eq   = (key_id == ent_id);
    res.date_eq = (key_date == ent_date);
    res.date_gt = (key_date > ent_date);
  end

endmodule

FILE: design/sorted_date_keyed_list.sv
// Sorted date-keyed list: holds up to CAPACITY (id, date) entries in ascending date order,
// newest first among equal dates. One item at a time moves through a small sequencer that
// walks the entries one per cycle through a single shared compare unit, then shifts the
// entries one per cycle to open or close a gap; a query's walk pauses while a match waits
// on a stalled output. Input stall stays high from acceptance until the final result is
// loaded into the output register; the next item is taken while that result still waits.
// Depends on sdkl_pkg and sdkl_cmp.
module sorted_date_keyed_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdkl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sdkl_pkg::out_item_t out_data
);
  import sdkl_pkg::*;

  state_t              state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [DATE_W-1:0]   date_r, date_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                pos_found_r, pos_found_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [MATCH_W-1:0]  nmatch_r, nmatch_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [1:0]          fin_status_r, fin_status_nxt;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [ID_W-1:0]     ids_r   [CAPACITY];
  logic [DATE_W-1:0]   dates_r [CAPACITY];

  logic [IDX_W-1:0]    rd_addr;
  logic [ID_W-1:0]     rd_id;
  logic [DATE_W-1:0]   rd_date;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ID_W-1:0]     wr_id;
  logic [DATE_W-1:0]   wr_date;
  logic                emit;
  out_item_t           emit_item;
  logic                out_free;
  logic [CNT_W-1:0]    idx_inc, idx_dec;
  logic [MATCH_W-1:0]  nmatch_inc;
  cmp_res_t            cmp;

  assign out_free   = !out_valid_r || !out_stall;
  assign idx_inc    = idx_r + CNT_W'(1);
  assign idx_dec    = idx_r - CNT_W'(1);
  assign nmatch_inc = nmatch_r + MATCH_W'(1);

  assign rd_id   = ids_r[rd_addr];
  assign rd_date = dates_r[rd_addr];

  sdkl_cmp u_cmp (
    .key_id   (id_r),
    .key_date (date_r),
    .ent_id   (rd_id),
    .ent_date (rd_date),
    .res      (cmp)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    date_nxt       = date_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    pos_found_nxt  = pos_found_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    nmatch_nxt     = nmatch_r;
    fill_nxt       = fill_r;
    fin_status_nxt = fin_status_r;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_id          = rd_id;
    wr_date        = rd_date;
    emit           = 1'b0;
    emit_item      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt       = in_data.mode;
          id_nxt         = in_data.person_id;
          date_nxt       = in_data.birth_date;
          idx_nxt        = '0;
          pos_found_nxt  = 1'b0;
          pend_valid_nxt = 1'b0;
          nmatch_nxt     = '0;
          if (in_data.mode == MODE_INSERT && fill_r >= CNT_W'(CAPACITY)) begin
            fin_status_nxt = STS_FULL;
            state_nxt      = S_FINISH;
          end else if (in_data.mode == MODE_INSERT || in_data.mode == MODE_REMOVE ||
                       in_data.mode == MODE_QUERY) begin
            state_nxt = S_SCAN;
          end else begin
            fin_status_nxt = STS_NOT_FOUND;
            state_nxt      = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        if (idx_r == fill_r) begin
          if (mode_r == MODE_INSERT) begin
            pos_nxt   = pos_found_r ? pos_r : fill_r;
            idx_nxt   = fill_r;
            state_nxt = S_SHIFT_UP;
          end else if (mode_r == MODE_REMOVE) begin
            fin_status_nxt = STS_NOT_FOUND;
            state_nxt      = S_FINISH;
          end else begin
            fin_status_nxt = pend_valid_r ? STS_DONE : STS_NOT_FOUND;
            state_nxt      = S_FINISH;
          end
        end else if (mode_r == MODE_INSERT) begin
          if (cmp.id_eq) begin
            fin_status_nxt = STS_DUP;
            state_nxt      = S_FINISH;
          end else begin
            // first entry whose date is not below the key: new entry goes in front of it
            if (!pos_found_r && !cmp.date_gt) begin
              pos_nxt       = idx_r;
              pos_found_nxt = 1'b1;
            end
            idx_nxt = idx_inc;
          end
        end else if (mode_r == MODE_REMOVE) begin
          if (cmp.id_eq) begin
            state_nxt = S_SHIFT_DN;
          end else begin
            idx_nxt = idx_inc;
          end
        end else begin
          if (!cmp.date_eq) begin
            idx_nxt = idx_inc;
          end else if (!pend_valid_r || out_free) begin
            // release the held match; the new one is held until we know if it is last
            if (pend_valid_r) begin
              emit                  = 1'b1;
              emit_item.status      = STS_DONE;
              emit_item.found       = 1'b1;
              emit_item.match_id    = pend_id_r;
              emit_item.entry_count = 5'(fill_r);
              emit_item.last        = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_id;
            nmatch_nxt     = nmatch_inc;
            idx_nxt        = idx_inc;
            if (nmatch_inc == MATCH_W'(MAX_RESULTS)) begin
              fin_status_nxt = STS_DONE;
              state_nxt      = S_FINISH;
            end
          end
        end
      end

      S_SHIFT_UP: begin
        rd_addr = idx_dec[IDX_W-1:0];
        wr_en   = 1'b1;
        if (idx_r == pos_r) begin
          wr_addr        = pos_r[IDX_W-1:0];
          wr_id          = id_r;
          wr_date        = date_r;
          fill_nxt       = fill_r + CNT_W'(1);
          fin_status_nxt = STS_DONE;
          state_nxt      = S_FINISH;
        end else begin
          idx_nxt = idx_dec;
        end
      end

      S_SHIFT_DN: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (idx_inc >= fill_r) begin
          fill_nxt       = fill_r - CNT_W'(1);
          fin_status_nxt = STS_DONE;
          state_nxt      = S_FINISH;
        end else begin
          wr_en   = 1'b1;
          idx_nxt = idx_inc;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.status      = fin_status_r;
          emit_item.found       = pend_valid_r;
          emit_item.match_id    = pend_valid_r ? pend_id_r : '0;
          emit_item.entry_count = 5'(fill_r);
          emit_item.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      pos_found_r  <= 1'b0;
      nmatch_r     <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      pend_valid_r <= pend_valid_nxt;
      pos_found_r  <= pos_found_nxt;
      nmatch_r     <= nmatch_nxt;
      idx_r        <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    date_r       <= date_nxt;
    pos_r        <= pos_nxt;
    pend_id_r    <= pend_id_nxt;
    fin_status_r <= fin_status_nxt;
    if (emit) begin
      out_r <= emit_item;
    end
    if (wr_en) begin
      ids_r[wr_addr]   <= wr_id;
      dates_r[wr_addr] <= wr_date;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded over a stalled result");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_UP) |-> (idx_r >= pos_r))
    else $error("shift index passed insert position");

  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == CNT_W'(CAPACITY)) |=> (fill_r <= CNT_W'(CAPACITY)))
    else $error("insert into full list");
`endif

endmodule

FILE: dv/tb_sorted_date_keyed_list.sv
// Testbench for sorted_date_keyed_list: directed and random insert, remove and query items,
// each result checked against a built-in model of the date-ordered list.
// Depends on sdkl_pkg and the RTL of sorted_date_keyed_list.
module tb_sorted_date_keyed_list;
  timeunit 1ns;
  timeprecision 1ps;

  import sdkl_pkg::*;

  localparam logic [1:0]        MODE_UNUSED = 2'd3;
  localparam logic [ID_W-1:0]   ID_MAX      = {ID_W{1'b1}};
  localparam logic [DATE_W-1:0] DATE_MAX    = {DATE_W{1'b1}};
  localparam int ITEMS       = 430;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;

  // Contents of the list as the block should hold them.
  typedef struct packed {
    logic [CAPACITY-1:0][ID_W-1:0]   ids;
    logic [CAPACITY-1:0][DATE_W-1:0] dates;
    logic [CNT_W-1:0]                fill;
  } roster_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  roster_t   gen_roster = '0;
  roster_t   live_roster = '0;
  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  int cycle_n = 0;
  int error_n = 0;
  int items_total = 0;
  int items_taken = 0;
  int items_offered = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_style = 0;
  int insert_n = 0, remove_n = 0, query_n = 0, unused_n = 0;
  int checked_n = 0, match_n = 0, full_n = 0, peak_fill = 0;

  sorted_date_keyed_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Apply one item to a list and return the results it causes.
  function automatic int roster_step(inout roster_t r, input in_item_t it,
                                     output out_item_t res [MAX_RESULTS]);
    int i, pos, at, n;
    n = 0;
    at = -1;
    foreach (res[k]) res[k] = '0;
    for (i = 0; i < r.fill; i++) begin
      if (at < 0 && r.ids[i] == it.person_id) at = i;
    end
    case (it.mode)
      MODE_INSERT: begin
        if (r.fill >= CAPACITY) begin
          res[0].status = STS_FULL;
        end else if (at >= 0) begin
          res[0].status = STS_DUP;
        end else begin
          pos = 0;
          while (pos < r.fill && it.birth_date > r.dates[pos]) pos++;
          for (i = r.fill; i > pos; i--) begin
            r.ids[i]   = r.ids[i-1];
            r.dates[i] = r.dates[i-1];
          end
          r.ids[pos]   = it.person_id;
          r.dates[pos] = it.birth_date;
          r.fill       = r.fill + 1'b1;
          res[0].status = STS_DONE;
        end
        n = 1;
      end
      MODE_REMOVE: begin
        if (at < 0) begin
          res[0].status = STS_NOT_FOUND;
        end else begin
          // close the gap
          for (i = at; i + 1 < r.fill; i++) begin
            r.ids[i]   = r.ids[i+1];
            r.dates[i] = r.dates[i+1];
          end
          r.fill = r.fill - 1'b1;
          res[0].status = STS_DONE;
        end
        n = 1;
      end
      MODE_QUERY: begin
        for (i = 0; i < r.fill && n < MAX_RESULTS; i++) begin
          if (r.dates[i] == it.birth_date) begin
            res[n].status   = STS_DONE;
            res[n].found    = 1'b1;
            res[n].match_id = r.ids[i];
            n++;
          end
        end
        if (n == 0) begin
          res[0].status = STS_NOT_FOUND;
          n = 1;
        end
      end
      default: begin
        res[0].status = STS_NOT_FOUND;
        n = 1;
      end
    endcase
    for (i = 0; i < n; i++) begin
      res[i].entry_count = r.fill;
      res[i].last        = (i == n - 1);
    end
    return n;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    if ($urandom_range(0, 7) == 0) return ID_W'($urandom);
    return ID_W'($urandom_range(0, 99999999));
  endfunction

  function automatic logic [ID_W-1:0] held_id();
    if (gen_roster.fill == 0) return fresh_id();
    return gen_roster.ids[$urandom_range(0, gen_roster.fill - 1)];
  endfunction

  function automatic logic [DATE_W-1:0] held_date();
    if (gen_roster.fill == 0) return DATE_W'($urandom);
    return gen_roster.dates[$urandom_range(0, gen_roster.fill - 1)];
  endfunction

  task automatic queue_item(logic [1:0] mode, logic [ID_W-1:0] id, logic [DATE_W-1:0] date);
    in_item_t  it;
    out_item_t scratch [MAX_RESULTS];
    it.mode       = mode;
    it.person_id  = id;
    it.birth_date = date;
    void'(roster_step(gen_roster, it, scratch));
    pending_q.push_back(it);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_n++;
    if (error_n <= 40)
      $display("[cycle %0d] mismatch on %0s: got 0x%0h, expected 0x%0h",
               cycle_n, what, got, want);
  endtask

  // Driver: bursts of items with random gaps; hold an item until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && items_offered != items_taken) begin
      // hold
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() > 0) begin
      in_data       <= pending_q.pop_front();
      in_valid      <= 1'b1;
      items_offered <= items_offered + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall: switch among free running, light, heavy and long stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_left % 24) < 18);
    endcase
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin : monitor
    out_item_t predicted [MAX_RESULTS];
    out_item_t want;
    int n;
    cycle_n++;
    if (rst_n && in_valid && !in_stall) begin
      n = roster_step(live_roster, in_data, predicted);
      for (int k = 0; k < n; k++) begin
        expected_q.push_back(predicted[k]);
        if (predicted[k].found) match_n++;
        if (predicted[k].status == STS_FULL) full_n++;
      end
      case (in_data.mode)
        MODE_INSERT: insert_n++;
        MODE_REMOVE: remove_n++;
        MODE_QUERY:  query_n++;
        default:     unused_n++;
      endcase
      if (live_roster.fill > peak_fill) peak_fill = live_roster.fill;
      items_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data, 0);
      end else begin
        want = expected_q.pop_front();
        checked_n++;
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.match_id !== want.match_id)
          report_mismatch("match_id", out_data.match_id, want.match_id);
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_data.entry_count, want.entry_count);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_n, expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [DATE_W-1:0] date_pool [4];
    logic [DATE_W-1:0] shared;
    logic [DATE_W-1:0] date;
    int style, run_len, roll, ins_w, rem_w;

    // Directed: empty list, unused mode, field extremes, duplicates, equal dates.
    queue_item(MODE_QUERY, '0, '0);
    queue_item(MODE_REMOVE, '0, '0);
    queue_item(MODE_UNUSED, ID_MAX, DATE_MAX);
    queue_item(MODE_UNUSED, '0, '0);
    queue_item(MODE_INSERT, '0, '0);
    queue_item(MODE_INSERT, ID_MAX, DATE_MAX);
    queue_item(MODE_INSERT, '0, 21'd1234);
    queue_item(MODE_INSERT, 27'd5, '0);
    queue_item(MODE_INSERT, 27'd99999999, 21'd1000);
    queue_item(MODE_QUERY, ID_MAX, '0);
    queue_item(MODE_QUERY, '0, DATE_MAX);
    queue_item(MODE_QUERY, '0, 21'd1000);
    queue_item(MODE_QUERY, '0, 21'd999);
    queue_item(MODE_REMOVE, '0, DATE_MAX);
    queue_item(MODE_REMOVE, '0, '0);
    queue_item(MODE_REMOVE, ID_MAX, '0);
    queue_item(MODE_REMOVE, 27'd99999999, '0);
    queue_item(MODE_REMOVE, 27'd5, '0);

    // Fill to capacity on one date, stream every match, hit full and duplicate, drain.
    repeat (2) begin
      shared = DATE_W'($urandom);
      while (gen_roster.fill < CAPACITY) queue_item(MODE_INSERT, fresh_id(), shared);
      queue_item(MODE_QUERY, '0, shared);
      queue_item(MODE_INSERT, fresh_id(), shared);
      queue_item(MODE_INSERT, held_id(), DATE_W'($urandom));
      queue_item(MODE_REMOVE, held_id(), '0);
      queue_item(MODE_INSERT, held_id(), shared);
      queue_item(MODE_REMOVE, fresh_id(), '0);
      while (gen_roster.fill > 0) queue_item(MODE_REMOVE, held_id(), DATE_W'($urandom));
    end

    date_pool[0] = '0;
    date_pool[1] = DATE_MAX;
    date_pool[2] = DATE_W'($urandom);
    date_pool[3] = DATE_W'($urandom);

    // Random runs that grow, shrink or churn the list.
    while (pending_q.size() < ITEMS) begin
      style   = $urandom_range(0, 2);
      run_len = $urandom_range(8, 40);
      ins_w   = (style == 0) ? 60 : (style == 1) ? 15 : 35;
      rem_w   = (style == 0) ? 15 : (style == 1) ? 60 : 30;
      repeat (run_len) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_w) begin
          case ($urandom_range(0, 5))
            0, 1, 2: date = date_pool[$urandom_range(0, 3)];
            3:       date = held_date();
            default: date = DATE_W'($urandom);
          endcase
          queue_item(MODE_INSERT, ($urandom_range(0, 6) == 0) ? held_id() : fresh_id(), date);
        end else if (roll < ins_w + rem_w) begin
          queue_item(MODE_REMOVE, ($urandom_range(0, 3) == 0) ? fresh_id() : held_id(),
                     DATE_W'($urandom));
        end else if (roll < 96) begin
          case ($urandom_range(0, 9))
            0, 1:    date = date_pool[$urandom_range(0, 3)];
            2:       date = DATE_W'($urandom);
            default: date = held_date();
          endcase
          queue_item(MODE_QUERY, ID_W'($urandom), date);
        end else begin
          queue_item(MODE_UNUSED, ID_W'($urandom), DATE_W'($urandom));
        end
      end
    end
    items_total = pending_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_taken < items_total || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d insert, %0d remove, %0d query, %0d unused mode",
             items_taken, insert_n, remove_n, query_n, unused_n);
    $display("checked %0d results, %0d matches, %0d full rejects, list depth up to %0d",
             checked_n, match_n, full_n, peak_fill);
    if (error_n == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_n);
      $display("status: fail");
    end
    $finish;
  end

endmodule
